@@ hdl/pcgb_pkg.sv @@
// ----------------------------------------------------------------------------
// pcgb_pkg
// Shared types, constants and the output permutation of the bounded
// random generator.
// ----------------------------------------------------------------------------
package pcgb_pkg;

    // lcg multiplier, split into halves for the shared 32x32 multiplier
    localparam logic [63:0] PCG_MULT    = 64'h5851_F42D_4C95_7F2D;
    localparam logic [31:0] PCG_MULT_LO = PCG_MULT[31:0];
    localparam logic [31:0] PCG_MULT_HI = PCG_MULT[63:32];

    // xorshift and rotate amounts of the output permutation
    localparam int XSH_SHIFT  = 18;
    localparam int XSH_OFFSET = 27;
    localparam int ROT_OFFSET = 59;

    // item modes
    localparam logic [1:0] MODE_RESEED  = 2'd0;
    localparam logic [1:0] MODE_RAW     = 2'd1;
    localparam logic [1:0] MODE_BOUNDED = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LL,
        S_LH,
        S_HL,
        S_UPD,
        S_SEED,
        S_BMUL,
        S_BCHK,
        S_MOD,
        S_THR,
        S_PUSH
    } t_state;

    // handshake between sequencer and remainder unit
    typedef struct packed {
        logic        start;
        logic [31:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_mod_rsp;

    // xorshift-high then random rotate of the old state
    function automatic logic [31:0] pcg_output(input logic [63:0] s);
        logic [63:0] x;
        logic [31:0] mixed;
        logic [4:0]  rot;
        logic [63:0] dbl;
        x     = (s >> XSH_SHIFT) ^ s;
        mixed = x[XSH_OFFSET +: 32];
        rot   = s[ROT_OFFSET +: 5];
        dbl   = {mixed, mixed} >> rot;
        return dbl[31:0];
    endfunction

endpackage

@@ hdl/pcg32_bounded_random.sv @@
// Raw draws, reseeds and bounded draws are handled one item at a time; a bounded
// draw needs the rejection threshold only when the low product word is under the
// range, and a rejected product starts a redraw. Each lcg step uses the shared
// 32x32 multiplier for three partial products; the threshold comes from the remainder unit.
// Reset (synchronous, active low) gives state 0, increment 1, seed 0.
// ----------------------------------------------------------------------------
// pcg32_bounded_random
// PCG32 generator with reseed, raw draws and unbiased bounded draws, built
// around one shared multiplier and a bit-serial remainder unit.
// ----------------------------------------------------------------------------
module pcg32_bounded_random (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_stream_select,
    input  logic [31:0] i_range_bound,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_random_value
);
    import pcgb_pkg::*;

    t_state      r_st, n_st;
    logic [63:0] r_state, n_state;
    logic [63:0] r_inc, n_inc;
    logic [63:0] r_seed;
    logic [63:0] r_acc, n_acc;
    logic [1:0]  r_mode, n_mode;
    logic        r_phase, n_phase;
    logic        r_have_thr, n_have_thr;
    logic [31:0] r_thr, n_thr;
    logic [31:0] r_range, n_range;
    logic [31:0] r_draw, n_draw;
    logic [31:0] r_low, n_low;
    logic [31:0] r_res, n_res;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_val, n_out_val;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;
    t_mod_req    mod_req;
    t_mod_rsp    mod_rsp;
    logic        in_xfer;
    logic        out_xfer;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;

    // shared multiplier
    pcgb_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // rejection threshold unit
    pcgb_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // sequencer: next state and datapath updates
    always_comb begin
        n_st        = r_st;
        n_state     = r_state;
        n_inc       = r_inc;
        n_acc       = r_acc;
        n_mode      = r_mode;
        n_phase     = r_phase;
        n_have_thr  = r_have_thr;
        n_thr       = r_thr;
        n_range     = r_range;
        n_draw      = r_draw;
        n_low       = r_low;
        n_res       = r_res;
        n_out_valid = r_out_valid && !out_xfer;
        n_out_val   = r_out_val;
        mul_a       = r_state[31:0];
        mul_b       = PCG_MULT_LO;
        mod_req.start   = 1'b0;
        mod_req.divisor = r_range;

        unique case (r_st)
            S_IDLE: begin
                if (in_xfer) begin
                    n_mode     = i_mode;
                    n_range    = i_range_bound;
                    n_have_thr = 1'b0;
                    n_phase    = 1'b0;
                    if (i_mode == MODE_RESEED) begin
                        n_state = 64'd0;
                        n_inc   = {i_stream_select[62:0], 1'b1};
                        n_st    = S_LL;
                    end else if (i_mode == MODE_RAW || i_mode == MODE_BOUNDED) begin
                        n_st = S_LL;
                    end
                end
            end
            // low x low partial product; output word from the old state
            S_LL: begin
                mul_a  = r_state[31:0];
                mul_b  = PCG_MULT_LO;
                n_draw = pcg_output(r_state);
                n_st   = S_LH;
            end
            S_LH: begin
                mul_a = r_state[31:0];
                mul_b = PCG_MULT_HI;
                n_acc = mul_prod + r_inc;
                n_st  = S_HL;
            end
            S_HL: begin
                mul_a = r_state[63:32];
                mul_b = PCG_MULT_LO;
                n_acc = {r_acc[63:32] + mul_prod[31:0], r_acc[31:0]};
                n_st  = S_UPD;
            end
            // fold in the last cross term and dispatch on mode
            S_UPD: begin
                n_state = {r_acc[63:32] + mul_prod[31:0], r_acc[31:0]};
                if (r_mode == MODE_RESEED) begin
                    n_st = r_phase ? S_IDLE : S_SEED;
                end else if (r_mode == MODE_RAW) begin
                    n_res = r_draw;
                    n_st  = S_PUSH;
                end else begin
                    n_st = S_BMUL;
                end
            end
            S_SEED: begin
                n_state = r_state + r_seed;
                n_phase = 1'b1;
                n_st    = S_LL;
            end
            // draw times range
            S_BMUL: begin
                mul_a = r_draw;
                mul_b = r_range;
                n_st  = S_BCHK;
            end
            S_BCHK: begin
                n_res = mul_prod[63:32];
                n_low = mul_prod[31:0];
                if (mul_prod[31:0] >= r_range) begin
                    n_st = S_PUSH;
                end else if (r_have_thr) begin
                    n_st = (mul_prod[31:0] < r_thr) ? S_LL : S_PUSH;
                end else begin
                    mod_req.start = 1'b1;
                    n_st          = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_rsp.done) begin
                    n_st = S_THR;
                end
            end
            S_THR: begin
                n_thr      = mod_rsp.rem;
                n_have_thr = 1'b1;
                n_st       = (r_low < mod_rsp.rem) ? S_LL : S_PUSH;
            end
            // wait for a free output register
            S_PUSH: begin
                if (!r_out_valid || out_xfer) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_res;
                    n_st        = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    // control and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_state     <= 64'd0;
            r_inc       <= 64'd1;
            r_seed      <= 64'd0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_RAW;
            r_phase     <= 1'b0;
            r_have_thr  <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_state     <= n_state;
            r_inc       <= n_inc;
            r_out_valid <= n_out_valid;
            r_mode      <= n_mode;
            r_phase     <= n_phase;
            r_have_thr  <= n_have_thr;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_thr     <= n_thr;
        r_range   <= n_range;
        r_draw    <= n_draw;
        r_low     <= n_low;
        r_res     <= n_res;
        r_out_val <= n_out_val;
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_st != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out_val;

endmodule

@@ hdl/pcgb_mul.sv @@
// ----------------------------------------------------------------------------
// pcgb_mul
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module pcgb_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);
    logic [63:0] r_prod;

    // product is registered and available in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ hdl/pcgb_mod.sv @@
// ----------------------------------------------------------------------------
// pcgb_mod
// Bit-serial remainder unit: computes (2^32 - d) mod d, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module pcgb_mod (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pcgb_pkg::t_mod_req i_req,
    output pcgb_pkg::t_mod_rsp o_rsp
);
    import pcgb_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_dvd, n_dvd;
    logic [31:0] r_div, n_div;
    logic [31:0] r_rem, n_rem;
    logic [32:0] trial;

    // one restoring-division step
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        trial  = {r_rem, r_dvd[31]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_dvd  = (~i_req.divisor) + 32'd1;
            n_div  = i_req.divisor;
            n_rem  = 32'd0;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = 32'(trial - {1'b0, r_div});
            end else begin
                n_rem = trial[31:0];
            end
            n_dvd = {r_dvd[30:0], 1'b0};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded random generator. Items are sent under
// random sender gaps and receiver stalls, all but the last phase. A scoreboard keeps
// its own copy of the generator state and the seed, and predicts every output word.
// The seed register is rewritten between phases, including its extreme values.
// ----------------------------------------------------------------------------

// prediction of generator output words, checked in transfer order
class draw_scoreboard;
    logic [63:0] seed;
    logic [63:0] lcg_state;
    logic [63:0] lcg_incr;
    logic [31:0] words_q[$];
    int          errors;

    function new();
        seed      = 64'd0;
        lcg_state = 64'd0;
        lcg_incr  = 64'd1;
        errors    = 0;
    endfunction

    // one lcg step; the output word comes from the state before the step
    function logic [31:0] advance();
        logic [63:0] prev;
        logic [31:0] xs;
        logic [4:0]  rot;
        prev      = lcg_state;
        lcg_state = prev * pcgb_pkg::PCG_MULT + lcg_incr;
        xs        = 32'(((prev >> 18) ^ prev) >> 27);
        rot       = prev[63:59];
        return (xs >> rot) | (xs << (5'd0 - rot));
    endfunction

    function logic [63:0] scaled_draw(input logic [31:0] bound);
        return {32'd0, advance()} * {32'd0, bound};
    endfunction

    function int pending();
        return words_q.size();
    endfunction

    // accepted input transfer: update state, queue the expected word if any
    function void note_item(input logic [1:0] mode, input logic [63:0] stream,
                            input logic [31:0] bound);
        logic [63:0] prod;
        logic [31:0] thr;
        case (mode)
            pcgb_pkg::MODE_RESEED: begin
                lcg_state = 64'd0;
                lcg_incr  = {stream[62:0], 1'b1};
                void'(advance());
                lcg_state = lcg_state + seed;
                void'(advance());
            end
            pcgb_pkg::MODE_RAW: begin
                words_q.insert(words_q.size(), advance());
            end
            pcgb_pkg::MODE_BOUNDED: begin
                prod = scaled_draw(bound);
                // reject low words under (2^32 - bound) mod bound
                if (prod[31:0] < bound) begin
                    thr = (32'd0 - bound) % bound;
                    while (prod[31:0] < thr)
                        prod = scaled_draw(bound);
                end
                words_q.insert(words_q.size(), prod[63:32]);
            end
            default: begin
                // unused mode is dropped without effect
            end
        endcase
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch: %s got %08h want %08h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // accepted output transfer against the oldest expected word
    task check_value(input logic [31:0] got);
        logic [31:0] want;
        if (words_q.size() == 0) begin
            report("unexpected random_value", got, 32'd0);
        end else begin
            want = words_q.pop_front();
            if (got !== want)
                report("random_value", got, want);
        end
    endtask
endclass

module tb;
    import pcgb_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS = 170;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic [63:0] i_stream_select;
    logic [31:0] i_range_bound;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_random_value;

    draw_scoreboard sb = new();
    bit  idle_on;
    int  stall_left;
    int  cycles;

    pcg32_bounded_random u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_stream_select (i_stream_select),
        .i_range_bound   (i_range_bound),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_random_value  (o_random_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result side: check accepted transfers, stall in random bursts
    initial begin
        i_out_stall = 1'b0;
        stall_left  = 0;
    end
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_value(o_random_value);
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left  <= $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // one input transfer, with an optional gap before it
    task automatic send_item(input logic [1:0] mode, input logic [63:0] stream,
                             input logic [31:0] bound);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_stream_select <= stream;
        i_range_bound   <= bound;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_item(mode, stream, bound);
    endtask

    // seed write once the block has gone quiet
    task automatic write_seed(input logic [63:0] value);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // a trailing reseed gives no result, so let it finish
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.seed = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 7))
            0: return $urandom_range(1, 16);
            1: return 32'h8000_0000 + $urandom_range(1, 64);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            3: return 32'd1 << $urandom_range(0, 31);
            4: return 32'd0;
            5: return $urandom() | 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [63:0] pick_stream();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 15));
            1: return {64{1'b1}};
            2: return {1'b1, 31'($urandom()), $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // random items; unused-mode items do not count
    task automatic run_random(input int count);
        int         sent;
        int         pick;
        logic [1:0] mode;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            mode = (pick < 8)  ? MODE_RESEED :
                   (pick < 45) ? MODE_RAW :
                   (pick < 95) ? MODE_BOUNDED : MODE_UNUSED;
            send_item(mode, pick_stream(), pick_bound());
            if (mode != MODE_UNUSED)
                sent++;
        end
    endtask

    initial begin
        logic [63:0] seeds[6];
        seeds[0] = {64{1'b1}};
        seeds[1] = {$urandom(), $urandom()};
        seeds[2] = 64'd1;
        seeds[3] = 64'h8000_0000_0000_0000;
        seeds[4] = {$urandom(), $urandom()};
        seeds[5] = 64'd0;

        idle_on         = 1'b1;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= 64'd0;
        i_in_valid      <= 1'b0;
        i_mode          <= MODE_RAW;
        i_stream_select <= 64'd0;
        i_range_bound   <= 32'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, zero range, ignored mode, stream extremes
        send_item(MODE_RAW, 64'd0, 32'd0);
        send_item(MODE_BOUNDED, 64'd0, 32'd0);
        send_item(MODE_BOUNDED, 64'd0, 32'd1);
        send_item(MODE_UNUSED, {64{1'b1}}, 32'hFFFF_FFFF);
        send_item(MODE_RAW, 64'd0, 32'd0);
        write_seed(64'd0);
        send_item(MODE_RESEED, 64'd0, 32'd0);
        send_item(MODE_RAW, 64'd0, 32'd0);
        send_item(MODE_RESEED, {64{1'b1}}, 32'd0);
        send_item(MODE_RAW, 64'd0, 32'd0);
        send_item(MODE_RESEED, 64'h8000_0000_0000_0000, 32'd0);
        send_item(MODE_RAW, 64'd0, 32'd0);
        send_item(MODE_BOUNDED, 64'd0, 32'hFFFF_FFFF);
        send_item(MODE_BOUNDED, 64'd0, 32'h8000_0000);
        // upper-half bounds reject about half the draws
        repeat (3) send_item(MODE_BOUNDED, 64'd0, 32'h8000_0001);
        send_item(MODE_BOUNDED, 64'd0, 32'd3);
        send_item(MODE_BOUNDED, 64'd0, 32'd7);
        send_item(MODE_BOUNDED, 64'd0, 32'h7FFF_FFFF);
        send_item(MODE_BOUNDED, 64'd0, 32'hFFFF_FFFE);
        send_item(MODE_RESEED, {$urandom(), $urandom()}, 32'd0);
        send_item(MODE_BOUNDED, {64{1'b1}}, 32'd0);
        send_item(MODE_UNUSED, 64'd0, 32'd0);
        send_item(MODE_RAW, 64'd0, 32'd0);

        // random phases over several seeds, quiet in the last one
        for (int p = 0; p < 6; p++) begin
            write_seed(seeds[p]);
            if (p == 5)
                idle_on = 1'b0;
            send_item(MODE_RESEED, pick_stream(), 32'd0);
            run_random(PHASE_ITEMS);
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

@@ files.f @@
hdl/pcgb_pkg.sv
hdl/pcgb_mul.sv
hdl/pcgb_mod.sv
hdl/pcg32_bounded_random.sv
test/tb.sv
